@@ src/azn_pkg.sv @@
`default_nettype none
package azn_pkg;

  localparam int DT_MAX      = 100;
  localparam int DT_DEFAULT  = 16;
  localparam int DT_W        = 7;
  localparam int GAIN_W      = 25;
  localparam int QDEPTH      = 2;
  localparam int TAU_MIN     = 10;
  localparam int MEAN_TAU_DEF = 1000;
  localparam int VAR_TAU_DEF  = 2000;

  localparam logic signed [31:0] MEAN_INIT = 32'sd32768;
  localparam logic [47:0] VAR_INIT  = 48'd6554;
  localparam logic [47:0] VAR_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] STD_FLOOR = 32'd66;
  localparam logic [14:0] CLIP_RESET = 15'd16384;
  localparam logic [14:0] ZMAG_SAT   = 15'h7FFF;

  typedef logic [GAIN_W-1:0] gain_tab_t [0:DT_MAX];

  typedef struct packed {
    logic signed [31:0] flux;
    logic [DT_W-1:0]    dt;
    logic               first;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MD, S_MLO, S_MHI, S_MUPD, S_DEV, S_SQ, S_VDIF,
    S_VLO, S_VHI, S_VUPD, S_SQRT, S_DSET, S_DIV, S_OUT
  } bstate_t;

  // gain table 1-exp(-dt/tau) in Q0.24; y = 1/tau in Q32
  function automatic gain_tab_t build_gains(input logic [63:0] y);
    logic [95:0] one;
    logic [95:0] term;
    logic [95:0] e;
    logic [95:0] p;
    gain_tab_t tab;
    one  = 96'd1 << 32;
    term = one;
    e    = one;
    term = ((term * 96'(y)) >> 32) / 1;
    e    = e - term;
    term = ((term * 96'(y)) >> 32) / 2;
    e    = e + term;
    term = ((term * 96'(y)) >> 32) / 3;
    e    = e - term;
    term = ((term * 96'(y)) >> 32) / 4;
    e    = e + term;
    term = ((term * 96'(y)) >> 32) / 5;
    e    = e - term;
    term = ((term * 96'(y)) >> 32) / 6;
    e    = e + term;
    p = one;
    tab[0] = '0;
    for (int dt = 1; dt <= DT_MAX; dt++) begin
      p = (p * e + 96'd2147483648) >> 32;
      tab[dt] = GAIN_W'((one - p + 96'd128) >> 8);
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

@@ src/azn_queue.sv @@
`default_nettype none
module azn_queue #(
  parameter int W     = 16,
  parameter int DEPTH = azn_pkg::QDEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [0:DEPTH-1];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   count;
  logic do_push;
  logic do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ src/azn_front.sv @@
`default_nettype none
module azn_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] flux_sample,
  input  wire logic [31:0]        time_ms,
  input  wire logic               qpop,
  output azn_pkg::item_t          qitem,
  output logic                    qempty
);
  logic        first_frame;
  logic [31:0] last_ts;
  logic [31:0] diff;
  logic [azn_pkg::DT_W-1:0] dt;
  azn_pkg::item_t item;
  logic accept;

  assign accept = push && !full;
  assign diff   = time_ms - last_ts;

  always_comb begin
    dt = azn_pkg::DT_W'(azn_pkg::DT_DEFAULT);
    if (!first_frame && (time_ms > last_ts)) begin
      if (diff > 32'(azn_pkg::DT_MAX)) begin
        dt = azn_pkg::DT_W'(azn_pkg::DT_MAX);
      end else begin
        dt = diff[azn_pkg::DT_W-1:0];
      end
    end
    item.flux  = flux_sample;
    item.dt    = dt;
    item.first = first_frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_frame <= 1'b1;
      last_ts     <= '0;
    end else if (accept) begin
      first_frame <= 1'b0;
      last_ts     <= time_ms;
    end
  end

  azn_queue #(
    .W($bits(azn_pkg::item_t))
  ) u_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (qpop),
    .rdata (qitem),
    .empty (qempty)
  );
endmodule
`default_nettype wire

@@ src/azn_back.sv @@
`default_nettype none
module azn_back #(
  parameter int MEAN_TAU_MS = azn_pkg::MEAN_TAU_DEF,
  parameter int VAR_TAU_MS  = azn_pkg::VAR_TAU_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           qempty,
  input  wire azn_pkg::item_t qitem,
  output logic                qpop,
  input  wire logic [14:0]    clip,
  input  wire logic           ofull,
  output logic                opush,
  output logic [15:0]         oz
);
  localparam int MT = (MEAN_TAU_MS < azn_pkg::TAU_MIN) ? azn_pkg::TAU_MIN : MEAN_TAU_MS;
  localparam int VT = (VAR_TAU_MS < azn_pkg::TAU_MIN) ? azn_pkg::TAU_MIN : VAR_TAU_MS;
  localparam logic [63:0] MY = (64'h1_0000_0000 + 64'(MT / 2)) / 64'(MT);
  localparam logic [63:0] VY = (64'h1_0000_0000 + 64'(VT / 2)) / 64'(VT);
  localparam azn_pkg::gain_tab_t GM = azn_pkg::build_gains(MY);
  localparam azn_pkg::gain_tab_t GV = azn_pkg::build_gains(VY);

  azn_pkg::bstate_t state;
  azn_pkg::bstate_t state_next;

  logic signed [31:0] mean;
  logic [47:0]        var_r;
  logic signed [31:0] flux;
  logic [azn_pkg::GAIN_W-1:0] gm;
  logic [azn_pkg::GAIN_W-1:0] gv;
  logic        dneg;
  logic [47:0] x;
  logic [49:0] acc;
  logic        devneg;
  logic [32:0] dev_mag;
  logic [47:0] tgt;
  logic        vup;
  logic [63:0] sv;
  logic [34:0] srem;
  logic [31:0] root;
  logic [3:0]  cnt;
  logic [45:0] drem;
  logic [45:0] dsh;
  logic [14:0] q;
  logic        sat;

  logic [23:0] mul_a;
  logic [azn_pkg::GAIN_W-1:0] mul_g;
  logic [48:0] prod;
  logic signed [32:0] d;
  logic signed [32:0] dev;
  logic [65:0] sq;
  logic [49:0] vsum;
  logic [47:0] var_next;
  logic [66:0] s1;
  logic [66:0] s2;
  logic [31:0] std_v;
  logic [45:0] num;
  logic [14:0] zmag;

  // one digit of the square root: {rem, root}
  function automatic logic [66:0] sqrt_step(input logic [34:0] rem, input logic [31:0] rt,
                                            input logic [1:0] bits);
    logic [34:0] r;
    logic [34:0] trial;
    logic [31:0] nr;
    r     = {rem[32:0], bits};
    trial = {1'b0, rt, 2'b01};
    if (r >= trial) begin
      r  = r - trial;
      nr = {rt[30:0], 1'b1};
    end else begin
      nr = {rt[30:0], 1'b0};
    end
    return {r, nr};
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      azn_pkg::S_IDLE: if (!qempty) state_next = azn_pkg::S_MD;
      azn_pkg::S_MD:   state_next = azn_pkg::S_MLO;
      azn_pkg::S_MLO:  state_next = azn_pkg::S_MHI;
      azn_pkg::S_MHI:  state_next = azn_pkg::S_MUPD;
      azn_pkg::S_MUPD: state_next = azn_pkg::S_DEV;
      azn_pkg::S_DEV:  state_next = azn_pkg::S_SQ;
      azn_pkg::S_SQ:   state_next = azn_pkg::S_VDIF;
      azn_pkg::S_VDIF: state_next = azn_pkg::S_VLO;
      azn_pkg::S_VLO:  state_next = azn_pkg::S_VHI;
      azn_pkg::S_VHI:  state_next = azn_pkg::S_VUPD;
      azn_pkg::S_VUPD: state_next = azn_pkg::S_SQRT;
      azn_pkg::S_SQRT: if (cnt == '0) state_next = azn_pkg::S_DSET;
      azn_pkg::S_DSET: state_next = azn_pkg::S_DIV;
      azn_pkg::S_DIV:  if (cnt == '0) state_next = azn_pkg::S_OUT;
      azn_pkg::S_OUT:  if (!ofull) state_next = azn_pkg::S_IDLE;
      default:         state_next = azn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    qpop  = (state == azn_pkg::S_IDLE) && !qempty;
    opush = (state == azn_pkg::S_OUT) && !ofull;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= azn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared gain multiplier, low and high halves of the operand in separate states
  always_comb begin
    mul_a = ((state == azn_pkg::S_MLO) || (state == azn_pkg::S_VLO)) ? x[23:0] : x[47:24];
    mul_g = ((state == azn_pkg::S_VLO) || (state == azn_pkg::S_VHI)) ? gv : gm;
    prod  = 49'(mul_a) * 49'(mul_g);
  end

  always_comb begin
    d   = 33'(flux) - 33'(mean);
    dev = 33'(flux) - 33'(mean);
    sq  = 66'(dev_mag) * 66'(dev_mag);
    vsum = 50'(var_r) + acc;
    if (vup) begin
      var_next = (vsum > 50'(azn_pkg::VAR_MAX)) ? azn_pkg::VAR_MAX : vsum[47:0];
    end else begin
      var_next = (acc > 50'(var_r)) ? '0 : var_r - acc[47:0];
    end
    s1 = sqrt_step(srem, root, sv[63:62]);
    s2 = sqrt_step(s1[66:32], s1[31:0], sv[61:60]);
    std_v = (root < azn_pkg::STD_FLOOR) ? azn_pkg::STD_FLOOR : root;
    num   = {1'b0, dev_mag, 12'b0} + 46'(std_v >> 1);
    zmag  = sat ? azn_pkg::ZMAG_SAT : q;
    if (zmag > clip) begin
      zmag = clip;
    end
    oz = devneg ? -{1'b0, zmag} : {1'b0, zmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean  <= azn_pkg::MEAN_INIT;
      var_r <= azn_pkg::VAR_INIT;
    end else begin
      if (qpop && qitem.first) begin
        mean  <= azn_pkg::MEAN_INIT;
        var_r <= azn_pkg::VAR_INIT;
      end
      if (state == azn_pkg::S_MUPD) begin
        mean <= dneg ? mean - $signed(acc[31:0]) : mean + $signed(acc[31:0]);
      end
      if (state == azn_pkg::S_VUPD) begin
        var_r <= var_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      azn_pkg::S_IDLE: begin
        if (qpop) begin
          flux <= qitem.flux;
          gm   <= GM[qitem.dt];
          gv   <= GV[qitem.dt];
        end
      end
      azn_pkg::S_MD: begin
        dneg <= d[32];
        x    <= 48'(d[32] ? -d : d);
      end
      azn_pkg::S_MLO, azn_pkg::S_VLO: begin
        acc <= 50'((prod + 49'h80_0000) >> 24);
      end
      azn_pkg::S_MHI, azn_pkg::S_VHI: begin
        acc <= acc + 50'(prod);
      end
      azn_pkg::S_DEV: begin
        devneg  <= dev[32];
        dev_mag <= dev[32] ? -dev : dev;
      end
      azn_pkg::S_SQ: begin
        tgt <= 48'((sq + 66'd32768) >> 16);
      end
      azn_pkg::S_VDIF: begin
        vup <= (tgt >= var_r);
        x   <= (tgt >= var_r) ? tgt - var_r : var_r - tgt;
      end
      azn_pkg::S_VUPD: begin
        sv   <= {var_next, 16'b0};
        srem <= '0;
        root <= '0;
        cnt  <= 4'd15;
      end
      azn_pkg::S_SQRT: begin
        srem <= s2[66:32];
        root <= s2[31:0];
        sv   <= {sv[59:0], 4'b0};
        cnt  <= cnt - 1'b1;
      end
      azn_pkg::S_DSET: begin
        sat  <= (47'(num) >= {std_v, 15'b0});
        drem <= num;
        dsh  <= {std_v, 14'b0};
        q    <= '0;
        cnt  <= 4'd14;
      end
      azn_pkg::S_DIV: begin
        if (drem >= dsh) begin
          drem <= drem - dsh;
          q    <= {q[13:0], 1'b1};
        end else begin
          q    <= {q[13:0], 1'b0};
        end
        dsh <= dsh >> 1;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

@@ src/adaptive_zscore_normalizer.sv @@
// The back-end sequencer takes one item at a time and pops the next only after the
// result of the last has gone to the output queue: square root at two bits a cycle
// and the z division at one quotient bit a cycle.
// A two-entry queue sits on each side, so input and output stall independently.
// Reset (rst, synchronous): queues empty, first-frame state set, clip limit 16384.
`default_nettype none
module adaptive_zscore_normalizer #(
  parameter int MEAN_TAU_MS = azn_pkg::MEAN_TAU_DEF,
  parameter int VAR_TAU_MS  = azn_pkg::VAR_TAU_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [31:0] flux_sample,
  input  wire logic [31:0]        time_ms,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      z_score,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [14:0]        cfg_data
);
  azn_pkg::item_t qitem;
  logic qpop;
  logic qempty;
  logic [14:0] clip;
  logic ofull;
  logic opush;
  logic [15:0] oz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= azn_pkg::CLIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clip <= cfg_data;
    end
  end

  azn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .flux_sample (flux_sample),
    .time_ms     (time_ms),
    .qpop        (qpop),
    .qitem       (qitem),
    .qempty      (qempty)
  );

  azn_back #(
    .MEAN_TAU_MS (MEAN_TAU_MS),
    .VAR_TAU_MS  (VAR_TAU_MS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qempty (qempty),
    .qitem  (qitem),
    .qpop   (qpop),
    .clip   (clip),
    .ofull  (ofull),
    .opush  (opush),
    .oz     (oz)
  );

  azn_queue #(
    .W(16)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (opush),
    .wdata (oz),
    .full  (ofull),
    .pop   (pop),
    .rdata (z_score),
    .empty (empty)
  );
endmodule
`default_nettype wire

@@ src/azn_checker.sv @@
`default_nettype none
module azn_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire logic signed [15:0] z_score
);
  // nothing can be waiting right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown after reset");
  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");
  // a waiting result is not lost without a pop
  a_hold: assert property (@(posedge clk) disable iff (rst) (!empty && !pop) |=> !empty)
    else $error("result dropped without transfer");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(z_score))
    else $error("result changed while waiting");
endmodule

bind adaptive_zscore_normalizer azn_checker u_chk (.*);
`default_nettype wire

@@ tb/tb_adaptive_zscore_normalizer.sv @@
`default_nettype none
module tb_adaptive_zscore_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic push, full, empty, pop;
  logic signed [31:0] flux_sample;
  logic [31:0] time_ms;
  logic signed [15:0] z_score;
  logic cfg_valid, cfg_ready;
  logic [14:0] cfg_data;

  adaptive_zscore_normalizer DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .flux_sample(flux_sample), .time_ms(time_ms),
    .empty(empty), .pop(pop), .z_score(z_score),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    logic signed [31:0] flux;
    logic [31:0] ts;
  } sample_t;

  sample_t pending_q[$];
  logic signed [15:0] z_expect_q[$];
  int errors = 0;
  bit quiet_end = 0;

  // predictor state
  logic [31:0] mean_gain [0:azn_pkg::DT_MAX];
  logic [31:0] var_gain [0:azn_pkg::DT_MAX];
  logic signed [31:0] p_mean;
  logic [63:0] p_var;
  bit p_first;
  logic [31:0] p_last_ts;
  logic [14:0] p_clip;

  function automatic void make_gains(input longint unsigned tau,
                                     output logic [31:0] tab [0:azn_pkg::DT_MAX]);
    longint unsigned y, term, r, p;
    longint e;
    if (tau < 10) tau = 10;
    y = (64'd4294967296 + tau / 2) / tau;
    e = 64'sd4294967296;
    term = 64'd4294967296;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * y) >> 32) / k;
      if (k % 2) e -= term;
      else e += term;
    end
    r = e;
    p = 64'd4294967296;
    tab[0] = 0;
    for (int dt = 1; dt <= azn_pkg::DT_MAX; dt++) begin
      p = (p * r + 64'd2147483648) >> 32;
      tab[dt] = 32'((64'd4294967296 - p + 128) >> 8);
    end
  endfunction

  function automatic longint unsigned scale_by_gain(longint unsigned mag, logic [31:0] g);
    return (mag >> 24) * g + (((mag & 64'hFFFFFF) * g + 64'h800000) >> 24);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] predict_z(sample_t s);
    longint flux, d, m, dev;
    longint unsigned mag, dmag, tgt, v, sd, zmag;
    int unsigned dt;
    flux = s.flux;
    dt = azn_pkg::DT_DEFAULT;
    if (!p_first && s.ts > p_last_ts) begin
      dt = s.ts - p_last_ts;
      if (dt > azn_pkg::DT_MAX) dt = azn_pkg::DT_MAX;
    end
    if (p_first) begin
      p_mean = azn_pkg::MEAN_INIT;
      p_var = 64'(azn_pkg::VAR_INIT);
    end
    p_first = 0;
    p_last_ts = s.ts;
    m = p_mean;
    d = flux - m;
    mag = (d < 0) ? -d : d;
    mag = scale_by_gain(mag, mean_gain[dt]);
    m = (d < 0) ? m - longint'(mag) : m + longint'(mag);
    p_mean = m[31:0];
    dev = flux - m;
    dmag = (dev < 0) ? -dev : dev;
    tgt = (dmag * dmag + 32768) >> 16;
    v = p_var;
    if (tgt >= v) begin
      v += scale_by_gain(tgt - v, var_gain[dt]);
      if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
    end else begin
      mag = scale_by_gain(v - tgt, var_gain[dt]);
      v = (mag > v) ? 0 : v - mag;
    end
    p_var = v;
    sd = int_sqrt(v << 16);
    if (sd < 66) sd = 66;
    zmag = (dmag * 4096 + sd / 2) / sd;
    if (zmag > 64'(p_clip)) zmag = 64'(p_clip);
    return 16'((dev < 0) ? -(longint'(zmag)) : longint'(zmag));
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int push_gap = 0;
  logic full_s;
  bit hold_send = 0;

  always @(negedge clk) begin
    if (rst) begin
      push <= 0;
    end else if (push && !full_s) begin
      // previous transfer done at posedge; decide next
      drive_next();
    end else if (!push) begin
      drive_next();
    end
  end
  always @(posedge clk) full_s <= full;

  task automatic drive_next();
    if (push_gap > 0) begin
      push_gap--;
      push <= 0;
    end else if (pending_q.size() == 0 || hold_send) begin
      push <= 0;
    end else begin
      flux_sample <= pending_q[0].flux;
      time_ms <= pending_q[0].ts;
      z_expect_q.push_back(predict_z(pending_q.pop_front()));
      push <= 1;
      if (!quiet_end && $urandom_range(0, 9) == 0) push_gap = $urandom_range(1, 12);
    end
  endtask

  // monitor
  int pop_gap = 0;
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (z_expect_q.size() == 0) begin
        $display("%0t: unexpected z_score, expected none, actual %0d", $time, z_score);
        errors++;
      end else begin
        if (z_score !== z_expect_q[0]) begin
          $display("%0t: z_score mismatch, expected %0d, actual %0d",
                   $time, z_expect_q[0], z_score);
          errors++;
        end
        void'(z_expect_q.pop_front());
      end
    end
  end
  always @(negedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      pop <= 0;
    end else begin
      pop <= 1;
      if (!quiet_end && $urandom_range(0, 9) == 0) pop_gap = $urandom_range(1, 12);
    end
  end

  // push is set at negedge; a transfer happens at posedge when push && !full.
  // full_s latches full at that edge so the driver knows whether it went through.

  task automatic write_clip(logic [14:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_clip = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || z_expect_q.size() != 0 || push) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic void add(logic signed [31:0] f, logic [31:0] t);
    sample_t s;
    s.flux = f;
    s.ts = t;
    pending_q.push_back(s);
  endfunction

  task automatic random_phase(int n, bit small_flux);
    logic [31:0] t;
    t = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: t = $urandom;
        1: t = t;
        2: t = t - $urandom_range(1, 50);
        3: t = t + $urandom_range(101, 100000);
        default: t = t + $urandom_range(1, 100);
      endcase
      if (small_flux || $urandom_range(0, 3) != 0)
        add($signed($urandom_range(0, 262143)) - 32'sd65536, t);
      else
        add($urandom, t);
    end
  endtask

  initial begin
    rst = 1;
    push = 0;
    pop = 0;
    flux_sample = 0;
    time_ms = 0;
    cfg_valid = 0;
    cfg_data = 0;
    make_gains(azn_pkg::MEAN_TAU_DEF, mean_gain);
    make_gains(azn_pkg::VAR_TAU_DEF, var_gain);
    p_mean = azn_pkg::MEAN_INIT;
    p_var = 64'(azn_pkg::VAR_INIT);
    p_first = 1;
    p_last_ts = 0;
    p_clip = azn_pkg::CLIP_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, stalled time, backward time, long gaps
    add(32'sh7FFF_FFFF, 0);
    add(32'sh8000_0000, 0);
    add(0, 16);
    add(32'sh0001_0000, 17);
    add(32'sh0001_0000, 5000);
    add(-32'sh0001_0000, 4000);
    add(32'sh0000_8000, 4100);
    add(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    add(32'sh8000_0000, 32'hFFFF_FFFF);
    add(32'sh1234_5678, 3);
    for (int i = 0; i < 8; i++) add(32'sh0000_8000, 200 + i * 16);
    hold_send = 1;
    hold_send = 0;
    wait_drained();

    write_clip(15'h7FFF);
    random_phase(300, 0);
    wait_drained();
    write_clip(15'd1);
    add(32'sh7FFF_FFFF, 10);
    add(32'sh8000_0000, 20);
    random_phase(150, 0);
    wait_drained();
    write_clip(15'd0);
    random_phase(50, 0);
    wait_drained();
    write_clip(15'h5555);
    random_phase(250, 1);
    wait_drained();
    write_clip(15'd4096);
    random_phase(200, 0);
    wait_drained();
    quiet_end = 1;
    write_clip(15'h2AAA);
    random_phase(180, 0);
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
